[hdl/srx_pkg.sv]
// ----------------------------------------------------------------------------
// srx_pkg
// Shared types, codes and the CRC-16 byte update of the SLIP frame receiver.
// ----------------------------------------------------------------------------
package srx_pkg;

  // Largest payload a frame may carry, and the buffer it implies
  localparam int MAX_PAYLOAD = 96;
  localparam int BUF_BYTES   = MAX_PAYLOAD + 5;

  // SLIP framing codes
  localparam logic [7:0] CODE_END       = 8'hC0;
  localparam logic [7:0] CODE_ESC       = 8'hDB;
  localparam logic [7:0] CODE_TRANS_END = 8'hDC;
  localparam logic [7:0] CODE_TRANS_ESC = 8'hDD;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
  localparam logic [2:0] KIND_ACK       = 3'd2;
  localparam logic [2:0] KIND_DUPLICATE = 3'd3;
  localparam logic [2:0] KIND_CRC_ERROR = 3'd4;
  localparam logic [2:0] KIND_MALFORMED = 3'd5;

  // One decoded link symbol: a data byte or a frame end
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } srx_token_t;

  // One result word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [7:0] frame_id;
    logic [7:0] frame_seq;
    logic [7:0] frame_len;
    logic [7:0] ack_seq_to_send;
    logic [7:0] acked_value;
  } srx_result_t;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[hdl/srx_ifs.sv]
// ----------------------------------------------------------------------------
// srx_ifs
// Valid/ready channels of the SLIP frame receiver: link bytes, configuration
// writes and result words.
// ----------------------------------------------------------------------------
interface srx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srx_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srx_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic [7:0] frame_id;
  logic [7:0] frame_seq;
  logic [7:0] frame_len;
  logic [7:0] ack_seq_to_send;
  logic [7:0] acked_value;
  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output frame_id, output frame_seq, output frame_len,
                  output ack_seq_to_send, output acked_value, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input frame_id, input frame_seq, input frame_len,
                  input ack_seq_to_send, input acked_value, output ready);
endinterface

[hdl/slip_crc16_frame_receiver.sv]
// ----------------------------------------------------------------------------
// slip_crc16_frame_receiver
// SLIP deframer with CRC-16/CCITT-FALSE check and frame verdicts.
// ----------------------------------------------------------------------------
// Raw link words enter on rx, one byte a word, and the block sustains one word
// per clock cycle while results are taken. The front unescapes SLIP (END
// 0xC0, ESC 0xDB) and pushes decoded symbols into a two-entry queue; the back
// parses frames of the form [id][seq][len][payload][crc lo][crc hi], keeps
// the CRC-16 two bytes behind the stream and writes at most one result word
// per symbol into an output register. A symbol is registered in the queue and
// its result in the output register. Payload bytes come out as kind 0 words
// while they arrive; END brings the verdict: accepted, ack frame (with its
// first payload byte), duplicate, CRC error or malformed. An empty frame, a
// lone ESC, and bytes beyond the declared length give no word. A byte that
// overflows the buffer is dropped and restarts the frame.
// Write ack_message_id on cfg only while the block is idle.
// ----------------------------------------------------------------------------
module slip_crc16_frame_receiver import srx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  srx_byte_if.sink      rx,
  srx_cfg_if.sink       cfg,
  srx_result_if.source  res
);

  logic [7:0] ack_message_id;

  logic       q_push;
  srx_token_t q_push_token;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  srx_token_t q_pop_token;

  // Configuration: always ready, hold the id of acknowledgement frames
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_message_id <= 8'd0;
    end else if (cfg.valid) begin
      ack_message_id <= cfg.data;
    end
  end

  // Front: unescape and classify link bytes
  srx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_token (q_push_token)
  );

  // Queue: decouple link stalls from result stalls
  srx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_token (q_push_token),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_token  (q_pop_token)
  );

  // Back: parse frames, check CRC, drive result words
  srx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ack_message_id (ack_message_id),
    .q_not_empty    (q_not_empty),
    .q_token        (q_pop_token),
    .q_pop          (q_pop),
    .res            (res)
  );

  // Payload words never point past the payload buffer
  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.kind == KIND_PAYLOAD)) |-> (res.payload_index < 7'(MAX_PAYLOAD)))
    else $error("payload index beyond buffer");

  // Only accepted and duplicate frames ask for an acknowledgement
  a_ack_seq: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.ack_seq_to_send != 8'd0)) |->
      ((res.kind == KIND_ACCEPTED) || (res.kind == KIND_DUPLICATE)))
    else $error("ack seq on wrong kind");

  // An acknowledged value only rides on an ack frame verdict
  a_acked_value: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.acked_value != 8'd0)) |-> (res.kind == KIND_ACK))
    else $error("acked value on wrong kind");

  // Queue never takes a symbol while full unless a pop frees an entry in the same cycle
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_full) |-> q_pop)
    else $error("symbol pushed into full queue");

endmodule

[hdl/srx_front.sv]
// ----------------------------------------------------------------------------
// srx_front
// Link side: accept raw bytes, undo SLIP escaping, push decoded symbols.
// ----------------------------------------------------------------------------
module srx_front import srx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  srx_byte_if.sink    rx,
  input  logic        q_full,
  output logic        q_push,
  output srx_token_t  q_token
);

  logic escape_pending;
  logic escape_pending_next;
  logic accept;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    escape_pending_next = escape_pending;
    q_push              = 1'b0;
    q_token.is_end      = 1'b0;
    q_token.data        = rx.rx_byte;
    if (accept) begin
      if (rx.rx_byte == CODE_END) begin
        // END always closes the frame and drops a pending escape
        q_push              = 1'b1;
        q_token.is_end      = 1'b1;
        escape_pending_next = 1'b0;
      end else if (escape_pending) begin
        q_push              = 1'b1;
        escape_pending_next = 1'b0;
        case (rx.rx_byte)
          CODE_TRANS_END: q_token.data = CODE_END;
          CODE_TRANS_ESC: q_token.data = CODE_ESC;
          default:        q_token.data = rx.rx_byte;
        endcase
      end else if (rx.rx_byte == CODE_ESC) begin
        escape_pending_next = 1'b1;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

[hdl/srx_queue.sv]
// ----------------------------------------------------------------------------
// srx_queue
// Two-entry symbol queue between the unescaper and the frame parser.
// ----------------------------------------------------------------------------
module srx_queue import srx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  srx_token_t  push_token,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output srx_token_t  pop_token
);

  srx_token_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_token = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/srx_back.sv]
// ----------------------------------------------------------------------------
// srx_back
// Frame parser: header capture, lagged CRC, payload streaming, end verdict
// and the result output register.
// ----------------------------------------------------------------------------
module srx_back import srx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    ack_message_id,
  input  logic          q_not_empty,
  input  srx_token_t    q_token,
  output logic          q_pop,
  srx_result_if.source  res
);

  logic [6:0]  byte_count,    byte_count_next;
  logic [7:0]  held_id,       held_id_next;
  logic [7:0]  held_seq,      held_seq_next;
  logic [7:0]  held_len,      held_len_next;
  logic [7:0]  first_payload, first_payload_next;
  logic [15:0] running_crc,   running_crc_next;
  logic [15:0] lag_bytes,     lag_bytes_next;
  logic [7:0]  last_peer_seq, last_peer_seq_next;

  logic        out_valid, out_valid_next;
  srx_result_t out_word;
  srx_result_t res_word;
  logic        res_valid;
  logic        len_ok;
  logic [6:0]  idx;

  // Take a symbol whenever the output register is free or being emptied
  assign q_pop = q_not_empty && (!out_valid || res.ready);

  assign len_ok = (byte_count >= 7'd5) &&
                  ({2'b00, byte_count} == ({1'b0, held_len} + 9'd5));
  assign idx    = byte_count - 7'd3;

  always_comb begin
    byte_count_next    = byte_count;
    held_id_next       = held_id;
    held_seq_next      = held_seq;
    held_len_next      = held_len;
    first_payload_next = first_payload;
    running_crc_next   = running_crc;
    lag_bytes_next     = lag_bytes;
    last_peer_seq_next = last_peer_seq;

    res_valid                = 1'b0;
    res_word.kind            = KIND_PAYLOAD;
    res_word.payload_byte    = 8'd0;
    res_word.payload_index   = 7'd0;
    res_word.frame_id        = held_id;
    res_word.frame_seq       = held_seq;
    res_word.frame_len       = held_len;
    res_word.ack_seq_to_send = 8'd0;
    res_word.acked_value     = 8'd0;

    if (q_token.is_end) begin
      if (byte_count != 7'd0) begin
        res_valid = 1'b1;
        if (!len_ok) begin
          res_word.kind = KIND_MALFORMED;
        end else if (running_crc != {lag_bytes[7:0], lag_bytes[15:8]}) begin
          res_word.kind = KIND_CRC_ERROR;
        end else if (held_id == ack_message_id) begin
          res_word.kind        = KIND_ACK;
          res_word.acked_value = (held_len != 8'd0) ? first_payload : 8'd0;
        end else if ((held_seq != 8'd0) && (held_seq == last_peer_seq)) begin
          res_word.kind            = KIND_DUPLICATE;
          res_word.ack_seq_to_send = held_seq;
        end else begin
          res_word.kind            = KIND_ACCEPTED;
          res_word.ack_seq_to_send = held_seq;
          if (held_seq != 8'd0) begin
            last_peer_seq_next = held_seq;
          end
        end
      end
      byte_count_next  = 7'd0;
      running_crc_next = CRC_INIT;
      lag_bytes_next   = 16'd0;
    end else if (byte_count >= 7'(BUF_BYTES)) begin
      // Overflow: drop the byte and restart the frame
      byte_count_next  = 7'd0;
      running_crc_next = CRC_INIT;
      lag_bytes_next   = 16'd0;
    end else begin
      if (byte_count >= 7'd2) begin
        running_crc_next = crc_feed(running_crc, lag_bytes[15:8]);
      end
      lag_bytes_next  = {lag_bytes[7:0], q_token.data};
      byte_count_next = byte_count + 7'd1;
      case (byte_count)
        7'd0: begin
          held_id_next       = q_token.data;
          held_seq_next      = 8'd0;
          held_len_next      = 8'd0;
          first_payload_next = 8'd0;
        end
        7'd1: held_seq_next = q_token.data;
        7'd2: held_len_next = q_token.data;
        default: begin
          if (idx == 7'd0) begin
            first_payload_next = q_token.data;
          end
          if (({1'b0, idx} < held_len) && (idx < 7'(MAX_PAYLOAD))) begin
            res_valid              = 1'b1;
            res_word.payload_byte  = q_token.data;
            res_word.payload_index = idx;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (q_pop) begin
      out_valid_next = res_valid;
    end else begin
      out_valid_next = out_valid && !res.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 7'd0;
      held_id       <= 8'd0;
      held_seq      <= 8'd0;
      held_len      <= 8'd0;
      first_payload <= 8'd0;
      running_crc   <= CRC_INIT;
      lag_bytes     <= 16'd0;
      last_peer_seq <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        byte_count    <= byte_count_next;
        held_id       <= held_id_next;
        held_seq      <= held_seq_next;
        held_len      <= held_len_next;
        first_payload <= first_payload_next;
        running_crc   <= running_crc_next;
        lag_bytes     <= lag_bytes_next;
        last_peer_seq <= last_peer_seq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_word <= res_word;
    end
  end

  assign res.valid           = out_valid;
  assign res.kind            = out_word.kind;
  assign res.payload_byte    = out_word.payload_byte;
  assign res.payload_index   = out_word.payload_index;
  assign res.frame_id        = out_word.frame_id;
  assign res.frame_seq       = out_word.frame_seq;
  assign res.frame_len       = out_word.frame_len;
  assign res.ack_seq_to_send = out_word.ack_seq_to_send;
  assign res.acked_value     = out_word.acked_value;

endmodule

[tb/tb_slip_crc16_frame_receiver.sv]
// ----------------------------------------------------------------------------
// tb_slip_crc16_frame_receiver
// Self-checking bench for the SLIP deframer with CRC-16 verdicts. Link words
// are fed through the rx channel with random gaps and the result channel is
// throttled at random. A frame tracker mirrors the deframer state and queues
// the result word that each accepted link word implies. Every result word is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_slip_crc16_frame_receiver import srx_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PCT       = 38;    // chance of an idle cycle on either side
  localparam int HOLD_CYCLES    = 400;   // long result back-pressure burst
  localparam int SETTLE_CYCLES  = 8;     // extra wait after every due result word is back
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam int PHASE_WORDS    = 270;

  typedef bit [7:0] byte_q_t[$];

  // Bitwise CRC-16/CCITT-FALSE update, MSB first
  function automatic bit [15:0] crc16_step(input bit [15:0] c, input bit [7:0] b);
    bit [15:0] r;
    bit        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Frame tracker: mirrors the deframer and holds the result words still due
  // --------------------------------------------------------------------------
  class frame_result_tracker;
    bit [7:0]    ack_id;
    bit [6:0]    count;
    bit          esc;
    bit [7:0]    id, seq, len, first_pl, last_seq;
    bit [15:0]   crc, lag;
    srx_result_t expected_words[$];
    int          errors;

    function new();
      ack_id   = 8'h00;
      esc      = 1'b0;
      id       = 8'h00;
      seq      = 8'h00;
      len      = 8'h00;
      first_pl = 8'h00;
      last_seq = 8'h00;
      errors   = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      count = '0;
      crc   = CRC_INIT;
      lag   = '0;
    endfunction

    function void set_ack_id(input bit [7:0] v);
      ack_id = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(input bit [2:0] kind, input bit [7:0] pb, input bit [6:0] pi,
                            input bit [7:0] aseq, input bit [7:0] aval);
      srx_result_t w;
      w.kind            = kind;
      w.payload_byte    = pb;
      w.payload_index   = pi;
      w.frame_id        = id;
      w.frame_seq       = seq;
      w.frame_len       = len;
      w.ack_seq_to_send = aseq;
      w.acked_value     = aval;
      expected_words.push_back(w);
    endfunction

    // Advance the mirror by one accepted link word
    function void take_link_byte(input bit [7:0] raw);
      bit [7:0] b;
      int       p;
      int       idx;
      b = raw;
      if (b == CODE_END) begin
        esc = 1'b0;
        if (count != 0) begin
          if (count < 5 || int'(count) != int'(len) + 5) begin
            push_word(KIND_MALFORMED, 8'h00, 7'h00, 8'h00, 8'h00);
          end else if (crc != {lag[7:0], lag[15:8]}) begin
            push_word(KIND_CRC_ERROR, 8'h00, 7'h00, 8'h00, 8'h00);
          end else if (id == ack_id) begin
            push_word(KIND_ACK, 8'h00, 7'h00, 8'h00, (len != 0) ? first_pl : 8'h00);
          end else if (seq != 0 && seq == last_seq) begin
            push_word(KIND_DUPLICATE, 8'h00, 7'h00, seq, 8'h00);
          end else begin
            if (seq != 0) begin
              last_seq = seq;
            end
            push_word(KIND_ACCEPTED, 8'h00, 7'h00, seq, 8'h00);
          end
        end
        restart_frame();
        return;
      end
      if (esc) begin
        esc = 1'b0;
        if (b == CODE_TRANS_END) begin
          b = CODE_END;
        end else if (b == CODE_TRANS_ESC) begin
          b = CODE_ESC;
        end
      end else if (b == CODE_ESC) begin
        esc = 1'b1;
        return;
      end
      p = count;
      if (p >= BUF_BYTES) begin
        restart_frame();
        return;
      end
      if (p >= 2) begin
        crc = crc16_step(crc, lag[15:8]);
      end
      lag   = {lag[7:0], b};
      count = 7'(p + 1);
      if (p == 0) begin
        id       = b;
        seq      = 8'h00;
        len      = 8'h00;
        first_pl = 8'h00;
      end else if (p == 1) begin
        seq = b;
      end else if (p == 2) begin
        len = b;
      end else begin
        idx = p - 3;
        if (idx == 0) begin
          first_pl = b;
        end
        if (idx < int'(len) && idx < MAX_PAYLOAD) begin
          push_word(KIND_PAYLOAD, b, 7'(idx), 8'h00, 8'h00);
        end
      end
    endfunction

    function bit field_differs(input string name, input int e, input int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_word(input srx_result_t got);
      srx_result_t exp;
      bit          bad;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d id 0x%0h",
                 $time, got.kind, got.frame_id);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      bad = 1'b0;
      bad |= field_differs("kind", exp.kind, got.kind);
      bad |= field_differs("payload_byte", exp.payload_byte, got.payload_byte);
      bad |= field_differs("payload_index", exp.payload_index, got.payload_index);
      bad |= field_differs("frame_id", exp.frame_id, got.frame_id);
      bad |= field_differs("frame_seq", exp.frame_seq, got.frame_seq);
      bad |= field_differs("frame_len", exp.frame_len, got.frame_len);
      bad |= field_differs("ack_seq_to_send", exp.ack_seq_to_send, got.ack_seq_to_send);
      bad |= field_differs("acked_value", exp.acked_value, got.acked_value);
      if (bad) begin
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  srx_byte_if   rx_if ();
  srx_cfg_if    cfg_if ();
  srx_result_if res_if ();

  slip_crc16_frame_receiver DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .cfg (cfg_if),
    .res (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_result_tracker tracker = new();

  bit       idle_on      = 1'b1;  // random idling on both sides
  bit       hold_request = 1'b0;  // ask the result side for one long stall
  int       link_words_sent = 0;
  bit [7:0] ack_id_now   = 8'h00;
  bit [7:0] recent_seq   = 8'h01; // reused to provoke duplicates
  int       quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Result side: random ready, with one long hold-off on request. The hold is
  // counted here so the sender keeps offering words and the block fills up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= (!idle_on || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Sample result words at the edge, where the handshake completes
  always @(posedge clk) begin : result_monitor
    srx_result_t got;
    if (res_if.valid && res_if.ready) begin
      got = {res_if.kind, res_if.payload_byte, res_if.payload_index, res_if.frame_id,
             res_if.frame_seq, res_if.frame_len, res_if.ack_seq_to_send,
             res_if.acked_value};
      tracker.check_word(got);
    end
  end

  // Watchdog: abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no handshake for %0d cycles, %0d words outstanding",
                 $time, quiet_cycles, tracker.pending());
        $display("[slip_crc16_frame_receiver] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Link side drivers
  // --------------------------------------------------------------------------

  // Offer one link word after an optional random gap; return once accepted
  task automatic send_byte(input bit [7:0] b);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        rx_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    tracker.take_link_byte(b);
    link_words_sent++;
  endtask

  // Send one decoded byte with proper SLIP escaping
  task automatic put_coded(input bit [7:0] b);
    if (b == CODE_END) begin
      send_byte(CODE_ESC);
      send_byte(CODE_TRANS_END);
    end else if (b == CODE_ESC) begin
      send_byte(CODE_ESC);
      send_byte(CODE_TRANS_ESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Random byte, biased towards the framing codes
  function automatic bit [7:0] pick_byte();
    case ($urandom_range(19))
      0:       return CODE_END;
      1:       return CODE_ESC;
      2:       return CODE_TRANS_END;
      3:       return CODE_TRANS_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build [id][seq][len][payload][crc lo][crc hi] and close it with END.
  // len_adj skews the declared length; loose_pct escapes plain bytes needlessly,
  // which the block must pass through unchanged.
  task automatic send_frame(input bit [7:0] id, input bit [7:0] seq, input int len_adj,
                            input byte_q_t pl, input bit bad_crc, input int loose_pct);
    bit [15:0] c;
    byte_q_t   body;
    body = {};
    body.push_back(id);
    body.push_back(seq);
    body.push_back(8'(pl.size() + len_adj));
    foreach (pl[i]) body.push_back(pl[i]);
    c = CRC_INIT;
    foreach (body[i]) c = crc16_step(c, body[i]);
    if (bad_crc) begin
      c = c ^ (16'h0001 << $urandom_range(15));
    end
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    foreach (body[i]) begin
      if (!(body[i] inside {CODE_END, CODE_TRANS_END, CODE_TRANS_ESC}) &&
          $urandom_range(99) < loose_pct) begin
        send_byte(CODE_ESC);
        send_byte(body[i]);
      end else begin
        put_coded(body[i]);
      end
    end
    send_byte(CODE_END);
  endtask

  // Drop valid and wait until every due result word has arrived, then linger
  task automatic settle(input int extra);
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write ack_message_id; only called while the block is idle
  task automatic write_ack_id(input bit [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    tracker.set_ack_id(v);
    ack_id_now = v;
  endtask

  // Mostly well-formed frames with random content, plus damaged ones and noise
  task automatic random_traffic(input int n);
    int       goal;
    int       r;
    int       plen;
    int       adj;
    byte_q_t  pl;
    bit [7:0] id;
    bit [7:0] seq;
    goal = link_words_sent + n;
    while (link_words_sent < goal) begin
      r    = $urandom_range(99);
      plen = ($urandom_range(19) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(8);
      pl   = {};
      repeat (plen) pl.push_back(pick_byte());
      id = ($urandom_range(5) == 0) ? ack_id_now : 8'($urandom);
      case ($urandom_range(3))
        0:       seq = 8'h00;
        1:       seq = recent_seq;
        default: seq = 8'($urandom);
      endcase
      if (r < 70) begin
        // well-formed frame, now and then with a bad checksum
        if ($urandom_range(1) == 1) begin
          send_byte(CODE_END);
        end
        send_frame(id, seq, 0, pl, $urandom_range(9) == 0, 25);
        if (seq != 0) begin
          recent_seq = seq;
        end
      end else if (r < 78) begin
        // declared length off by a few bytes either way
        adj = $urandom_range(1, 3);
        if ($urandom_range(1) == 1) begin
          adj = -adj;
        end
        send_frame(id, seq, adj, pl, 1'b0, 0);
      end else if (r < 86) begin
        // raw noise, framing codes included
        repeat ($urandom_range(1, 10)) send_byte(pick_byte());
      end else if (r < 94) begin
        // truncated frame
        repeat ($urandom_range(1, 4)) put_coded(pick_byte());
        send_byte(CODE_END);
      end else if (r < 98) begin
        // ESC cut short by END
        if ($urandom_range(1) == 1) begin
          send_byte(8'($urandom_range(1, 191)));
        end
        send_byte(CODE_ESC);
        send_byte(CODE_END);
      end else begin
        // overrun the buffer
        repeat ($urandom_range(BUF_BYTES + 1, BUF_BYTES + 6)) put_coded(pick_byte());
        send_byte(CODE_END);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    byte_q_t  pl;
    bit [7:0] v;

    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with id 0x00 marking ack frames
    write_ack_id(8'h00);
    send_byte(CODE_END);                                   // empty frame: no word
    pl = {};
    send_frame(8'h01, 8'h00, 0, pl, 1'b0, 0);              // unreliable, accepted
    pl = {8'h05};
    send_frame(8'h00, 8'h11, 0, pl, 1'b0, 0);              // ack carrying 0x05
    pl = {};
    send_frame(8'h00, 8'h00, 0, pl, 1'b0, 0);              // ack with no payload
    pl = {8'h00, 8'hFF};
    send_frame(8'hFF, 8'h07, 0, pl, 1'b0, 0);              // reliable, accepted
    send_frame(8'hFF, 8'h07, 0, pl, 1'b0, 0);              // same seq: duplicate
    pl = {};
    send_frame(8'h04, 8'h00, 0, pl, 1'b0, 0);              // seq 0 never duplicates
    pl = {8'h33};
    send_frame(8'h02, 8'h09, 0, pl, 1'b1, 0);              // checksum error
    send_byte(8'h01);                                      // too short: malformed
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(CODE_END);
    pl = {CODE_END, CODE_ESC, CODE_TRANS_END, CODE_TRANS_ESC};
    send_frame(CODE_END, CODE_ESC, 0, pl, 1'b0, 0);        // escaped codes everywhere
    pl = {8'h41, CODE_ESC, 8'h42};
    send_frame(8'h03, 8'h22, 0, pl, 1'b0, 100);            // needless escapes pass through
    send_byte(8'h10);                                      // END right after ESC
    send_byte(CODE_ESC);
    send_byte(CODE_END);
    send_byte(CODE_ESC);                                   // lone ESC, empty frame
    send_byte(CODE_END);
    pl = {8'hA0, 8'hA1};
    send_frame(8'h05, 8'h23, 1, pl, 1'b0, 0);              // declared length too long
    pl = {8'hB0, 8'hB1, 8'hB2};
    send_frame(8'h06, 8'h24, -1, pl, 1'b0, 0);             // bytes past declared length
    send_frame(8'h07, 8'h25, 252, pl, 1'b0, 0);            // length 255
    pl = {};
    for (int i = 0; i < MAX_PAYLOAD; i++) pl.push_back(8'(i * 7 + 3));
    send_frame(8'h08, 8'h26, 0, pl, 1'b0, 0);              // largest payload
    repeat (BUF_BYTES + 2) put_coded(pick_byte());         // overrun, then restart
    send_byte(CODE_END);
    settle(SETTLE_CYCLES);

    // Random phases, each under its own ack id
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       v = 8'hFF;
        1:       v = 8'h5A;
        2:       v = 8'h01;
        5:       v = 8'h00;
        default: v = 8'($urandom);
      endcase
      write_ack_id(v);
      idle_on = (ph != 2);        // one phase runs flat out on both sides
      if (ph == 3) begin
        hold_request = 1'b1;      // stall results while words keep coming
      end
      if (ph == 4) begin
        random_traffic(PHASE_WORDS / 2);
        settle(0);                // hold the sender until every word is back
        random_traffic(PHASE_WORDS / 2);
      end else begin
        random_traffic(PHASE_WORDS);
      end
      settle(SETTLE_CYCLES);
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[slip_crc16_frame_receiver] OK");
    end else begin
      $display("[slip_crc16_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
